FILE: rtl/core/pafu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pafu_pkg
// shared types, constants and the sequencer control store for the pwm audio
// fifo unit
// ----------------------------------------------------------------------------
package pafu_pkg;

  localparam int DUTY_W   = 12;
  localparam int PER_W    = 12;
  localparam int HALF_W   = PER_W - 1;
  localparam int IRQD_W   = 4;
  localparam int MODE_W   = 3;
  localparam int EL_W     = 6;
  localparam int ACC_W    = 13;
  localparam int SAMPLE_W = 16;
  localparam int RUN_W    = 6;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  // magnitude of (duty - half) times full scale, and the divider step count
  localparam int NUM_W    = DUTY_W + 15;
  localparam int DSTEP_W  = 5;

  localparam logic [ACC_W-1:0]    ACC_MAX     = 13'h1FFF;
  localparam logic [RUN_W-1:0]    MAX_PERIODS = 6'd63;
  localparam logic [NUM_W-1:0]    POS_LIMIT   = 27'd32767;
  localparam logic [NUM_W-1:0]    NEG_LIMIT   = 27'd32768;
  localparam logic [SAMPLE_W-1:0] PCM_MAX     = 16'h7FFF;
  localparam logic [SAMPLE_W-1:0] PCM_MIN     = 16'h8000;

  // item modes
  localparam logic [MODE_W-1:0] MODE_TICK      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PUSH_L    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PUSH_R    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_PUSH_MONO = 3'd3;
  localparam logic [MODE_W-1:0] MODE_STATUS    = 3'd4;

  // register indexes (word address bit)
  localparam logic REG_PERIOD  = 1'b0;
  localparam logic REG_IRQ_DIV = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_PUSH, S_TICK, S_CHECK, S_POP, S_CONV, S_DIVL, S_DIVR, S_EMIT
  } step_t;

  typedef enum logic [3:0] {
    A_NONE, A_LOAD, A_PUSH, A_ACC, A_POP, A_CONV_L, A_CONV_R, A_STORE_R, A_EMIT
  } action_t;

  typedef enum logic [1:0] {
    W_NONE, W_IN, W_DIV, W_OUT
  } wait_t;

  typedef enum logic [1:0] {
    B_NEXT, B_JUMP, B_MODE, B_DONE
  } branch_t;

  typedef struct packed {
    action_t act;
    wait_t   wt;
    branch_t br;
    step_t   target;
  } ucode_t;

  typedef struct packed {
    logic              start;
    logic [DUTY_W-1:0] duty;
    logic [HALF_W-1:0] half;
  } pcm_req_t;

  // control store: a step repeats while its wait holds, then acts and branches
  function automatic ucode_t ucode_rom(step_t pc);
    ucode_t uc;
    case (pc)
      S_IDLE:  uc = '{A_LOAD,    W_IN,   B_MODE, S_IDLE};
      S_PUSH:  uc = '{A_PUSH,    W_NONE, B_JUMP, S_IDLE};
      S_TICK:  uc = '{A_ACC,     W_NONE, B_NEXT, S_IDLE};
      S_CHECK: uc = '{A_NONE,    W_NONE, B_DONE, S_IDLE};
      S_POP:   uc = '{A_POP,     W_NONE, B_NEXT, S_IDLE};
      S_CONV:  uc = '{A_CONV_L,  W_NONE, B_NEXT, S_IDLE};
      S_DIVL:  uc = '{A_CONV_R,  W_DIV,  B_NEXT, S_IDLE};
      S_DIVR:  uc = '{A_STORE_R, W_DIV,  B_NEXT, S_IDLE};
      S_EMIT:  uc = '{A_EMIT,    W_OUT,  B_JUMP, S_CHECK};
      default: uc = '{A_NONE,    W_NONE, B_JUMP, S_IDLE};
    endcase
    return uc;
  endfunction

  // dispatch table for an accepted item
  function automatic step_t mode_entry(logic [MODE_W-1:0] mode);
    step_t s;
    case (mode)
      MODE_TICK:      s = S_TICK;
      MODE_PUSH_L:    s = S_PUSH;
      MODE_PUSH_R:    s = S_PUSH;
      MODE_PUSH_MONO: s = S_PUSH;
      MODE_STATUS:    s = S_CONV;
      default:        s = S_IDLE;
    endcase
    return s;
  endfunction

endpackage

FILE: rtl/core/pafu_pcm_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pafu_pcm_div
// duty to signed pcm conversion, restoring division one quotient bit a cycle
// ----------------------------------------------------------------------------
module pafu_pcm_div
  import pafu_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  pcm_req_t                   req,
  output logic                       busy,
  output logic signed [SAMPLE_W-1:0] sample
);

  logic                busy_r, busy_nxt;
  logic [DSTEP_W-1:0]  steps_r, steps_nxt;
  logic [HALF_W-1:0]   half_r, half_nxt;
  logic [HALF_W-1:0]   rem_r, rem_nxt;
  logic [NUM_W-1:0]    quo_r, quo_nxt;
  logic                neg_r, neg_nxt;
  logic                zero_r, zero_nxt;

  logic [DUTY_W:0]     diff;
  logic [DUTY_W-1:0]   mag;
  logic [HALF_W:0]     trial;
  logic [HALF_W:0]     trial_sub;
  logic                ge;

  assign diff      = {1'b0, req.duty} - {2'b00, req.half};
  assign mag       = diff[DUTY_W] ? DUTY_W'(-diff) : diff[DUTY_W-1:0];
  assign trial     = {rem_r, quo_r[NUM_W-1]};
  assign ge        = trial >= {1'b0, half_r};
  assign trial_sub = trial - {1'b0, half_r};

  always_comb begin
    busy_nxt  = busy_r;
    steps_nxt = steps_r;
    half_nxt  = half_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    neg_nxt   = neg_r;
    zero_nxt  = zero_r;
    if (req.start) begin
      busy_nxt  = 1'b1;
      steps_nxt = DSTEP_W'(NUM_W);
      half_nxt  = req.half;
      rem_nxt   = '0;
      // mag * 32767 as a shift and subtract
      quo_nxt   = {mag, 15'b0} - NUM_W'(mag);
      neg_nxt   = diff[DUTY_W];
      zero_nxt  = (req.half == '0);
    end else if (busy_r) begin
      rem_nxt   = ge ? trial_sub[HALF_W-1:0] : trial[HALF_W-1:0];
      quo_nxt   = {quo_r[NUM_W-2:0], ge};
      steps_nxt = steps_r - 1'b1;
      busy_nxt  = (steps_r != DSTEP_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    steps_r <= steps_nxt;
    half_r  <= half_nxt;
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    neg_r   <= neg_nxt;
    zero_r  <= zero_nxt;
  end

  // saturate the truncated quotient and apply the sign
  always_comb begin
    if (zero_r) begin
      sample = '0;
    end else if (neg_r) begin
      sample = (quo_r > NEG_LIMIT) ? PCM_MIN : SAMPLE_W'(~quo_r[SAMPLE_W-1:0] + 1'b1);
    end else begin
      sample = (quo_r > POS_LIMIT) ? PCM_MAX : quo_r[SAMPLE_W-1:0];
    end
  end

  assign busy = busy_r;

endmodule

FILE: rtl/core/pwm_audio_fifo_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwm_audio_fifo_unit
// stereo pwm sound unit: duty fifos per side, period stepping and pcm output
// ----------------------------------------------------------------------------
// channel   | handshake                    | moves
// ----------+------------------------------+-----------------------------------
// in_       | in_valid / in_ready          | mode, duty, elapsed cycles
// out_      | out_valid / out_ready        | sample pair, irq, fifo flags, last
// apb       | psel, penable, pwrite/pready | period, irq_divider
//
// a push is loaded and then stored; every sample pair (one per period, or a status
// read) comes from the shared 27-step pcm divider, run once per side
// a tick steps the accumulator, then emits one pair for each period it completes
// rst_n is synchronous; it clears the fifos, held duties, accumulator, irq count
// and registers, and leaves the sequencer in its idle step
// the next item can be taken while the last result waits in the output register;
// a stalled output only holds the sequencer at its emit step
// ----------------------------------------------------------------------------
module pwm_audio_fifo_unit
  import pafu_pkg::*;
#(
  parameter int FIFO_DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ADDR_W-1:0]          paddr,
  input  logic [DATA_W-1:0]          pwdata,
  output logic [DATA_W-1:0]          prdata,
  output logic                       pready,
  // item input
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [MODE_W-1:0]          in_mode,
  input  logic [DUTY_W-1:0]          in_duty,
  input  logic [EL_W-1:0]            in_elapsed_cycles,
  // results
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_left_sample,
  output logic signed [SAMPLE_W-1:0] out_right_sample,
  output logic                       out_pwm_irq,
  output logic                       out_left_full,
  output logic                       out_left_empty,
  output logic                       out_right_full,
  output logic                       out_right_empty,
  output logic                       out_last
);

  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int IDX_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

  // sequencer
  step_t               pc_r, pc_nxt;
  ucode_t              uc;
  logic                stall;
  logic                fire;
  logic                more;

  // registers
  logic [PER_W-1:0]    period_r, period_nxt;
  logic [IRQD_W-1:0]   irq_div_r, irq_div_nxt;

  // item latch
  logic [MODE_W-1:0]   mode_r, mode_nxt;
  logic [DUTY_W-1:0]   duty_r, duty_nxt;
  logic [EL_W-1:0]     el_r, el_nxt;
  logic                status_r, status_nxt;

  // fifos and held duties
  logic [DUTY_W-1:0]   q_l_r [FIFO_DEPTH];
  logic [DUTY_W-1:0]   q_l_nxt [FIFO_DEPTH];
  logic [DUTY_W-1:0]   q_r_r [FIFO_DEPTH];
  logic [DUTY_W-1:0]   q_r_nxt [FIFO_DEPTH];
  logic [CNT_W-1:0]    cnt_l_r, cnt_l_nxt;
  logic [CNT_W-1:0]    cnt_r_r, cnt_r_nxt;
  logic [DUTY_W-1:0]   held_l_r, held_l_nxt;
  logic [DUTY_W-1:0]   held_r_r, held_r_nxt;

  // period stepping
  logic [ACC_W-1:0]    acc_r, acc_nxt;
  logic [ACC_W:0]      acc_sum;
  logic [IRQD_W-1:0]   irq_cnt_r, irq_cnt_nxt;
  logic [IRQD_W-1:0]   irq_inc;
  logic [RUN_W-1:0]    run_r, run_nxt;
  logic                irq_r, irq_nxt;

  // conversion
  pcm_req_t                   div_req;
  logic                       div_busy;
  logic signed [SAMPLE_W-1:0] div_sample;
  logic signed [SAMPLE_W-1:0] smp_l_r, smp_l_nxt;
  logic signed [SAMPLE_W-1:0] smp_r_r, smp_r_nxt;

  // output register
  logic                       ov_r, ov_nxt;
  logic signed [SAMPLE_W-1:0] o_left_r, o_left_nxt;
  logic signed [SAMPLE_W-1:0] o_right_r, o_right_nxt;
  logic                       o_irq_r, o_irq_nxt;
  logic                       o_lf_r, o_lf_nxt;
  logic                       o_le_r, o_le_nxt;
  logic                       o_rf_r, o_rf_nxt;
  logic                       o_re_r, o_re_nxt;
  logic                       o_last_r, o_last_nxt;

  logic                       cfg_wr;

  // ---------------------------------------------------------------------------
  // apb registers
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    period_nxt  = period_r;
    irq_div_nxt = irq_div_r;
    if (cfg_wr) begin
      case (paddr[ADDR_W-1])
        REG_PERIOD:  period_nxt  = pwdata[PER_W-1:0];
        REG_IRQ_DIV: irq_div_nxt = pwdata[IRQD_W-1:0];
        default:     period_nxt  = period_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[ADDR_W-1])
      REG_PERIOD:  prdata = DATA_W'(period_r);
      REG_IRQ_DIV: prdata = DATA_W'(irq_div_r);
      default:     prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // sequencer: fetch the control word, hold on its wait, then branch
  // ---------------------------------------------------------------------------
  assign uc = ucode_rom(pc_r);

  always_comb begin
    case (uc.wt)
      W_IN:    stall = !in_valid;
      W_DIV:   stall = div_busy;
      W_OUT:   stall = ov_r && !out_ready;
      default: stall = 1'b0;
    endcase
  end

  assign fire     = !stall;
  assign in_ready = (uc.wt == W_IN);

  // another whole period is due within this tick
  assign more = !status_r && (period_r != '0) && (acc_r >= {1'b0, period_r})
                && (run_r != MAX_PERIODS);

  always_comb begin
    if (stall) begin
      pc_nxt = pc_r;
    end else begin
      case (uc.br)
        B_NEXT:  pc_nxt = step_t'(4'(pc_r) + 4'd1);
        B_JUMP:  pc_nxt = uc.target;
        B_MODE:  pc_nxt = mode_entry(in_mode);
        B_DONE:  pc_nxt = more ? step_t'(4'(pc_r) + 4'd1) : uc.target;
        default: pc_nxt = S_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // datapath, driven by the action field
  // ---------------------------------------------------------------------------
  assign acc_sum = (ACC_W + 1)'(acc_r) + (ACC_W + 1)'(el_r);
  assign irq_inc = irq_cnt_r + 1'b1;

  always_comb begin
    mode_nxt    = mode_r;
    duty_nxt    = duty_r;
    el_nxt      = el_r;
    status_nxt  = status_r;
    q_l_nxt     = q_l_r;
    q_r_nxt     = q_r_r;
    cnt_l_nxt   = cnt_l_r;
    cnt_r_nxt   = cnt_r_r;
    held_l_nxt  = held_l_r;
    held_r_nxt  = held_r_r;
    acc_nxt     = acc_r;
    irq_cnt_nxt = irq_cnt_r;
    run_nxt     = run_r;
    irq_nxt     = irq_r;
    smp_l_nxt   = smp_l_r;
    smp_r_nxt   = smp_r_r;
    div_req       = '0;
    div_req.duty  = held_l_r;
    div_req.half  = period_r[PER_W-1:1];
    o_left_nxt  = o_left_r;
    o_right_nxt = o_right_r;
    o_irq_nxt   = o_irq_r;
    o_lf_nxt    = o_lf_r;
    o_le_nxt    = o_le_r;
    o_rf_nxt    = o_rf_r;
    o_re_nxt    = o_re_r;
    o_last_nxt  = o_last_r;
    ov_nxt      = ov_r && !out_ready;

    if (fire) begin
      case (uc.act)
        A_LOAD: begin
          mode_nxt   = in_mode;
          duty_nxt   = in_duty;
          el_nxt     = in_elapsed_cycles;
          status_nxt = (in_mode == MODE_STATUS);
          run_nxt    = '0;
          irq_nxt    = 1'b0;
        end
        A_PUSH: begin
          // a push into a full fifo is dropped
          if ((mode_r == MODE_PUSH_L || mode_r == MODE_PUSH_MONO) && cnt_l_r != CNT_FULL) begin
            q_l_nxt[cnt_l_r[IDX_W-1:0]] = duty_r;
            cnt_l_nxt = cnt_l_r + 1'b1;
          end
          if ((mode_r == MODE_PUSH_R || mode_r == MODE_PUSH_MONO) && cnt_r_r != CNT_FULL) begin
            q_r_nxt[cnt_r_r[IDX_W-1:0]] = duty_r;
            cnt_r_nxt = cnt_r_r + 1'b1;
          end
        end
        A_ACC: begin
          // zero period leaves the accumulator alone
          if (period_r != '0) begin
            acc_nxt = (acc_sum > (ACC_W + 1)'(ACC_MAX)) ? ACC_MAX : acc_sum[ACC_W-1:0];
          end
        end
        A_POP: begin
          acc_nxt = acc_r - {1'b0, period_r};
          run_nxt = run_r + 1'b1;
          if (cnt_l_r != '0) begin
            held_l_nxt = q_l_r[0];
            cnt_l_nxt  = cnt_l_r - 1'b1;
            for (int i = 0; i < FIFO_DEPTH - 1; i++) begin
              q_l_nxt[i] = q_l_r[i + 1];
            end
          end
          if (cnt_r_r != '0) begin
            held_r_nxt = q_r_r[0];
            cnt_r_nxt  = cnt_r_r - 1'b1;
            for (int i = 0; i < FIFO_DEPTH - 1; i++) begin
              q_r_nxt[i] = q_r_r[i + 1];
            end
          end
          irq_nxt = 1'b0;
          if (irq_div_r != '0) begin
            if (irq_inc >= irq_div_r) begin
              irq_cnt_nxt = '0;
              irq_nxt     = 1'b1;
            end else begin
              irq_cnt_nxt = irq_inc;
            end
          end
        end
        A_CONV_L: begin
          div_req.start = 1'b1;
        end
        A_CONV_R: begin
          smp_l_nxt     = div_sample;
          div_req.start = 1'b1;
          div_req.duty  = held_r_r;
        end
        A_STORE_R: begin
          smp_r_nxt = div_sample;
        end
        A_EMIT: begin
          // flags are taken after this period's pops
          ov_nxt      = 1'b1;
          o_left_nxt  = smp_l_r;
          o_right_nxt = smp_r_r;
          o_irq_nxt   = irq_r;
          o_lf_nxt    = (cnt_l_r == CNT_FULL);
          o_le_nxt    = (cnt_l_r == '0);
          o_rf_nxt    = (cnt_r_r == CNT_FULL);
          o_re_nxt    = (cnt_r_r == '0);
          o_last_nxt  = !more;
        end
        default: begin
          ov_nxt = ov_r && !out_ready;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // shared pcm divider
  // ---------------------------------------------------------------------------
  pafu_pcm_div u_pcm_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (div_req),
    .busy   (div_busy),
    .sample (div_sample)
  );

  // ---------------------------------------------------------------------------
  // control state and registered outputs
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r      <= S_IDLE;
      period_r  <= '0;
      irq_div_r <= '0;
      cnt_l_r   <= '0;
      cnt_r_r   <= '0;
      held_l_r  <= '0;
      held_r_r  <= '0;
      acc_r     <= '0;
      irq_cnt_r <= '0;
      ov_r      <= 1'b0;
    end else begin
      pc_r      <= pc_nxt;
      period_r  <= period_nxt;
      irq_div_r <= irq_div_nxt;
      cnt_l_r   <= cnt_l_nxt;
      cnt_r_r   <= cnt_r_nxt;
      held_l_r  <= held_l_nxt;
      held_r_r  <= held_r_nxt;
      acc_r     <= acc_nxt;
      irq_cnt_r <= irq_cnt_nxt;
      ov_r      <= ov_nxt;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    mode_r    <= mode_nxt;
    duty_r    <= duty_nxt;
    el_r      <= el_nxt;
    status_r  <= status_nxt;
    q_l_r     <= q_l_nxt;
    q_r_r     <= q_r_nxt;
    run_r     <= run_nxt;
    irq_r     <= irq_nxt;
    smp_l_r   <= smp_l_nxt;
    smp_r_r   <= smp_r_nxt;
    o_left_r  <= o_left_nxt;
    o_right_r <= o_right_nxt;
    o_irq_r   <= o_irq_nxt;
    o_lf_r    <= o_lf_nxt;
    o_le_r    <= o_le_nxt;
    o_rf_r    <= o_rf_nxt;
    o_re_r    <= o_re_nxt;
    o_last_r  <= o_last_nxt;
  end

  assign out_valid        = ov_r;
  assign out_left_sample  = o_left_r;
  assign out_right_sample = o_right_r;
  assign out_pwm_irq      = o_irq_r;
  assign out_left_full    = o_lf_r;
  assign out_left_empty   = o_le_r;
  assign out_right_full   = o_rf_r;
  assign out_right_empty  = o_re_r;
  assign out_last         = o_last_r;

endmodule

FILE: rtl/core/pafu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pafu_checker
// port level checks for the pwm audio fifo unit, bound to the top level
// ----------------------------------------------------------------------------
module pafu_checker
  import pafu_pkg::*;
(
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [SAMPLE_W-1:0] out_left_sample,
  input logic signed [SAMPLE_W-1:0] out_right_sample,
  input logic                       out_pwm_irq,
  input logic                       out_left_full,
  input logic                       out_left_empty,
  input logic                       out_right_full,
  input logic                       out_right_empty,
  input logic                       out_last
);

  // reset leaves no result pending and the sequencer ready for an item
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("pafu: not idle after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_left_sample)
      && $stable(out_right_sample) && $stable(out_pwm_irq) && $stable(out_last))
    else $error("pafu: stalled result changed");

  // a fifo is never full and empty at once
  a_left_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_left_full && out_left_empty))
    else $error("pafu: left fifo flags conflict");

  a_right_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_right_full && out_right_empty))
    else $error("pafu: right fifo flags conflict");

endmodule

bind pwm_audio_fifo_unit pafu_checker u_pafu_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_left_sample  (out_left_sample),
  .out_right_sample (out_right_sample),
  .out_pwm_irq      (out_pwm_irq),
  .out_left_full    (out_left_full),
  .out_left_empty   (out_left_empty),
  .out_right_full   (out_right_full),
  .out_right_empty  (out_right_empty),
  .out_last         (out_last)
);
